// ===== sv/bitmap_text_renderer_defines.svh =====
// Assertion macros used by the checker file.
`ifndef BITMAP_TEXT_RENDERER_DEFINES_SVH
`define BITMAP_TEXT_RENDERER_DEFINES_SVH

// Same-cycle implication.
`define BTR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BTR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must never hold.
`define BTR_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

// ===== sv/brt_pkg.sv =====
// Shared types, codes and helpers of the bitmap text renderer.
package brt_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int COORD_W     = 18;
  localparam int BASE_W      = 26;

  localparam logic [1:0] ACT_ROW     = 2'd0;
  localparam logic [1:0] ACT_NEWLINE = 2'd1;
  localparam logic [1:0] ACT_START   = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_WIDTH   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_HEIGHT  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_INK_RED       = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_INK_GREEN     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_INK_BLUE      = 3'd6;

  typedef struct packed {
    logic load;
    logic calc;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic calc_empty;
    logic pix;
    logic rest_empty;
  } sts_t;

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  // w - w/5 for w up to 16, w/5 taken as (w*13)>>6
  function automatic logic [4:0] glyph_advance(input logic [4:0] w);
    logic [8:0] p;
    p = {4'b0, w} * 9'd13;
    return w - {2'b0, p[8:6]};
  endfunction

endpackage

// ===== sv/brt_ctrl.sv =====
// Controller state machine of the bitmap text renderer.
module brt_ctrl import brt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] action,
  input  logic       out_ready,
  input  sts_t       sts,
  output logic       in_ready,
  output logic       out_valid,
  output cmd_t       cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (action == ACT_ROW) state_next = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = sts.calc_empty ? S_IDLE : S_SCAN;
      end
      S_SCAN: begin
        out_valid = sts.pix;
        cmd.step  = !sts.pix || out_ready;
        if (cmd.step && sts.rest_empty) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== sv/brt_datapath.sv =====
// Datapath of the bitmap text renderer: registers, pen state, clip mask and addressing.
module brt_datapath import brt_pkg::*; #(
  parameter int MAX_GLYPH_WIDTH  = 16,
  parameter int MAX_GLYPH_HEIGHT = 32,
  parameter int MAX_SCREEN_SIZE  = 4096
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [1:0]             action,
  input  logic [15:0]            row_bits,
  input  logic signed [12:0]     start_x,
  input  logic signed [12:0]     start_y,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  output logic [23:0]            pixel_index,
  output logic [15:0]            pixel_color,
  output logic                   last_write
);

  localparam int LANES = (MAX_GLYPH_WIDTH < 16) ? MAX_GLYPH_WIDTH : 16;
  localparam logic [4:0]  W_CAP = 5'(LANES);
  localparam logic [5:0]  H_CAP = 6'((MAX_GLYPH_HEIGHT < 32) ? MAX_GLYPH_HEIGHT : 32);
  localparam logic [12:0] S_CAP = 13'((MAX_SCREEN_SIZE < 8191) ? MAX_SCREEN_SIZE : 8191);

  logic [12:0] screen_width, screen_height;
  logic [4:0]  glyph_width;
  logic [5:0]  glyph_height;
  logic [4:0]  ink_red, ink_blue;
  logic [5:0]  ink_green;

  logic signed [12:0] origin_col, origin_row;
  logic [15:0] pen_col, pen_row;
  logic [4:0]  glyph_row_count;

  logic [15:0]               bits_reg;
  logic signed [COORD_W-1:0] x_reg, y_reg;
  logic [BASE_W-1:0]         row_base;
  logic [LANES-1:0]          mask, mask_calc, mask_rest;

  logic [4:0]  w_eff;
  logic [5:0]  h_eff;
  logic [12:0] sw_eff, sh_eff;
  logic signed [COORD_W-1:0] x_next, y_next;
  logic        row_end;
  logic        y_ok;
  logic [BASE_W-1:0] index_sum;

  assign w_eff  = (glyph_width > W_CAP) ? W_CAP : glyph_width;
  assign h_eff  = (glyph_height > H_CAP) ? H_CAP : glyph_height;
  assign sw_eff = (screen_width > S_CAP) ? S_CAP : screen_width;
  assign sh_eff = (screen_height > S_CAP) ? S_CAP : screen_height;

  assign x_next = COORD_W'(origin_col) + $signed({2'b0, pen_col});
  assign y_next = COORD_W'(origin_row) + $signed({2'b0, pen_row})
                + $signed({13'b0, glyph_row_count});
  assign row_end = (h_eff == 6'd0) || (({1'b0, glyph_row_count} + 6'd1) >= h_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= 13'd640;
      screen_height <= 13'd480;
      glyph_width   <= 5'd8;
      glyph_height  <= 6'd16;
      ink_red       <= 5'd31;
      ink_green     <= 6'd63;
      ink_blue      <= 5'd31;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        REG_GLYPH_WIDTH:   glyph_width   <= cfg_data[4:0];
        REG_GLYPH_HEIGHT:  glyph_height  <= cfg_data[5:0];
        REG_INK_RED:       ink_red       <= cfg_data[4:0];
        REG_INK_GREEN:     ink_green     <= cfg_data[5:0];
        REG_INK_BLUE:      ink_blue      <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_col      <= '0;
      origin_row      <= '0;
      pen_col         <= '0;
      pen_row         <= '0;
      glyph_row_count <= '0;
    end else if (cmd.load) begin
      case (action)
        ACT_START: begin
          origin_col      <= start_x;
          origin_row      <= start_y;
          pen_col         <= '0;
          pen_row         <= '0;
          glyph_row_count <= '0;
        end
        ACT_NEWLINE: begin
          pen_col         <= '0;
          pen_row         <= sat_add16(pen_row, {10'b0, h_eff});
          glyph_row_count <= '0;
        end
        ACT_ROW: begin
          if (row_end) begin
            glyph_row_count <= '0;
            pen_col         <= sat_add16(pen_col, {11'b0, glyph_advance(w_eff)});
          end else begin
            glyph_row_count <= glyph_row_count + 5'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign y_ok = !y_reg[COORD_W-1] && (y_reg < $signed({5'b0, sh_eff}));

  always_comb begin
    logic signed [COORD_W-1:0] lane_x;
    logic [4:0] bit_sel;
    mask_calc = '0;
    for (int i = 0; i < LANES; i++) begin
      lane_x  = x_reg + COORD_W'(i);
      bit_sel = w_eff - 5'd1 - 5'(i);
      mask_calc[i] = (5'(i) < w_eff) && bits_reg[bit_sel[3:0]] && y_ok
                   && !lane_x[COORD_W-1] && (lane_x < $signed({5'b0, sw_eff}));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && action == ACT_ROW) begin
      bits_reg <= row_bits;
      x_reg    <= x_next;
      y_reg    <= y_next;
    end else if (cmd.step) begin
      x_reg <= x_reg + COORD_W'(1);
    end
    if (cmd.calc) begin
      mask     <= mask_calc;
      row_base <= BASE_W'(y_reg[12:0]) * BASE_W'(sw_eff);
    end else if (cmd.step) begin
      mask <= mask >> 1;
    end
  end

  assign mask_rest      = mask >> 1;
  assign sts.calc_empty = (mask_calc == '0);
  assign sts.pix        = mask[0];
  assign sts.rest_empty = (mask_rest == '0);

  assign index_sum   = row_base + BASE_W'(x_reg[12:0]);
  assign pixel_index = index_sum[23:0];
  assign pixel_color = {ink_red, ink_green, ink_blue};
  assign last_write  = sts.rest_empty;

endmodule

// ===== sv/bitmap_text_renderer.sv =====
// Top level of the bitmap text renderer.
// Start and newline requests, and the unused action code, leave the block idle, so it can
// take a new request in the next cycle. A glyph row latches the pen, then builds its clip
// mask and row base (y times screen width), then scans positions up to its last on-screen
// set bit, at most the glyph width of them, waiting while the output is held by the sink.
// The single scan register serves one row at a time. Configuration writes are taken in
// any cycle and must arrive only while the block is idle.
module bitmap_text_renderer import brt_pkg::*; #(
  parameter int MAX_GLYPH_WIDTH  = 16,
  parameter int MAX_GLYPH_HEIGHT = 32,
  parameter int MAX_SCREEN_SIZE  = 4096
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             action,
  input  logic [15:0]            row_bits,
  input  logic signed [12:0]     start_x,
  input  logic signed [12:0]     start_y,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [23:0]            pixel_index,
  output logic [15:0]            pixel_color,
  output logic                   last_write
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  brt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .action    (action),
    .out_ready (out_ready),
    .sts       (sts),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  brt_datapath #(
    .MAX_GLYPH_WIDTH  (MAX_GLYPH_WIDTH),
    .MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT),
    .MAX_SCREEN_SIZE  (MAX_SCREEN_SIZE)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .action      (action),
    .row_bits    (row_bits),
    .start_x     (start_x),
    .start_y     (start_y),
    .cmd         (cmd),
    .sts         (sts),
    .pixel_index (pixel_index),
    .pixel_color (pixel_color),
    .last_write  (last_write)
  );

endmodule

// ===== sv/brt_checker.sv =====
// Port-level assertions of the bitmap text renderer, bound to the top level.
`include "bitmap_text_renderer_defines.svh"

module brt_checker import brt_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  action,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] pixel_index,
  input logic        last_write
);

  `BTR_ASSERT_NEVER(a_no_overlap, clk, rst, in_ready && out_valid, "request taken during scan")
  `BTR_ASSERT_NEXT(a_ctl_quick, clk, rst, in_valid && in_ready && action != ACT_ROW, in_ready, "control request not one cycle")
  `BTR_ASSERT_NEXT(a_row_busy, clk, rst, in_valid && in_ready && action == ACT_ROW, !in_ready && !out_valid, "glyph row skipped mask stage")
  `BTR_ASSERT_NEXT(a_more_follow, clk, rst, out_valid && out_ready && !last_write, !in_ready, "row ended before last write")
  `BTR_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(pixel_index), "stalled write changed")

endmodule

bind bitmap_text_renderer brt_checker u_brt_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .action      (action),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .pixel_index (pixel_index),
  .last_write  (last_write)
);
